>>> src/oakt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oakt_pkg
// shared types and constants of the open addressing key table
// ---------------------------------------------------------------------------
package oakt_pkg;

  localparam int KEY_W        = 64;
  localparam int SLOT_W       = 10;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;
  localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int               MIX_SHIFT = 33;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_KEY = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                found;
    logic                inserted;
    logic [STATUS_W-1:0] status;
  } oakt_res_t;

endpackage

>>> src/oakt_hash.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oakt_hash
// 64-bit finalizer mix on one shared 32x32 multiplier
// ---------------------------------------------------------------------------
module oakt_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [oakt_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [oakt_pkg::KEY_W-1:0] hash
);
  import oakt_pkg::*;

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_MUL0 = 5'b00010,
    H_MUL1 = 5'b00100,
    H_MUL2 = 5'b01000,
    H_MUL3 = 5'b10000
  } hash_state_t;

  hash_state_t      state_r, state_nxt;
  logic             round_r, round_nxt;
  logic             done_r, done_nxt;
  logic [KEY_W-1:0] x_r, x_nxt;
  logic [KEY_W-1:0] acc_r, acc_nxt;
  logic [KEY_W-1:0] prod_r, prod_nxt;
  logic [KEY_W-1:0] mul_c;
  logic [31:0]      mul_a, mul_b;
  logic [KEY_W-1:0] mul_p;
  logic [KEY_W-1:0] sum;

  assign mul_c = round_r ? MIX_MUL_B : MIX_MUL_A;
  assign mul_p = KEY_W'(mul_a) * KEY_W'(mul_b);
  assign sum   = acc_r + {prod_r[31:0], 32'b0};

  // operand select: low x low, low x high, high x low
  always_comb begin
    case (state_r)
      H_MUL1: begin
        mul_a = x_r[31:0];
        mul_b = mul_c[63:32];
      end
      H_MUL2: begin
        mul_a = x_r[63:32];
        mul_b = mul_c[31:0];
      end
      default: begin
        mul_a = x_r[31:0];
        mul_b = mul_c[31:0];
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    done_nxt  = 1'b0;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    case (state_r)
      H_IDLE: begin
        if (start) begin
          x_nxt     = key ^ (key >> MIX_SHIFT);
          round_nxt = 1'b0;
          state_nxt = H_MUL0;
        end
      end
      H_MUL0: begin
        prod_nxt  = mul_p;
        state_nxt = H_MUL1;
      end
      H_MUL1: begin
        acc_nxt   = prod_r;
        prod_nxt  = mul_p;
        state_nxt = H_MUL2;
      end
      H_MUL2: begin
        acc_nxt   = sum;
        prod_nxt  = mul_p;
        state_nxt = H_MUL3;
      end
      H_MUL3: begin
        x_nxt = sum ^ (sum >> MIX_SHIFT);
        if (round_r) begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          round_nxt = 1'b1;
          state_nxt = H_MUL0;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      round_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign done = done_r;
  assign hash = x_r;

endmodule

>>> src/oakt_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oakt_table
// slot memory with clearing pass, triangular probe walk and insert
// ---------------------------------------------------------------------------
module oakt_table #(
  parameter int CAPACITY = oakt_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       cmd,
  input  logic [oakt_pkg::KEY_W-1:0] key,
  input  logic [AW-1:0]              hash_idx,
  output logic                       ready,
  output logic                       done,
  output oakt_pkg::oakt_res_t        res
);
  import oakt_pkg::*;

  localparam logic [AW-1:0] LAST_IDX  = AW'(CAPACITY - 1);
  localparam logic [AW-1:0] HALF_LOAD = AW'(CAPACITY / 2);

  typedef enum logic [2:0] {
    T_CLEAR = 3'b001,
    T_IDLE  = 3'b010,
    T_PROBE = 3'b100
  } tbl_state_t;

  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rd_data_r;

  tbl_state_t    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] first_r, first_nxt;
  logic [AW-1:0] probe_r, probe_nxt;
  logic          done_r, done_nxt;
  oakt_res_t     res_r, res_nxt;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             hit_key, hit_empty, last_probe;

  assign hit_key    = (rd_data_r == key);
  assign hit_empty  = (rd_data_r == EMPTY_KEY);
  assign last_probe = (probe_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    probe_nxt = probe_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = key;
    case (state_r)
      T_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = EMPTY_KEY;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = T_IDLE;
        end
      end
      T_IDLE: begin
        if (start) begin
          idx_nxt   = hash_idx;
          first_nxt = hash_idx;
          probe_nxt = '0;
          rd_en     = 1'b1;
          rd_addr   = hash_idx;
          state_nxt = T_PROBE;
        end
      end
      T_PROBE: begin
        res_nxt.found    = 1'b0;
        res_nxt.inserted = 1'b0;
        res_nxt.status   = STATUS_OK;
        res_nxt.slot     = SLOT_W'(idx_r);
        if (hit_key) begin
          res_nxt.found = 1'b1;
          done_nxt      = 1'b1;
          state_nxt     = T_IDLE;
        end else if (hit_empty) begin
          if (cmd == CMD_INSERT) begin
            if (count_r >= HALF_LOAD) begin
              res_nxt.status = STATUS_FULL;
            end else begin
              wr_en            = 1'b1;
              count_nxt        = count_r + 1'b1;
              res_nxt.inserted = 1'b1;
            end
          end
          done_nxt  = 1'b1;
          state_nxt = T_IDLE;
        end else if (last_probe) begin
          // path exhausted: report the home slot, refuse an insert
          res_nxt.slot = SLOT_W'(first_r);
          if (cmd == CMD_INSERT) begin
            res_nxt.status = STATUS_FULL;
          end
          done_nxt  = 1'b1;
          state_nxt = T_IDLE;
        end else begin
          idx_nxt   = idx_r + probe_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          rd_en     = 1'b1;
          rd_addr   = idx_nxt;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    probe_r <= probe_nxt;
    res_r   <= res_nxt;
  end

  assign ready = (state_r == T_IDLE);
  assign done  = done_r;
  assign res   = res_r;

endmodule

>>> src/open_addressing_key_table_top.sv
`timescale 1ns / 1ps
// flow: an accepted key is hashed, then walks its probe path, one read per probe, then its result
//   is registered for out_valid; a key equal to the empty marker skips the hash and the probe walk
// throughput: one word at a time; the next word is not taken until the result leaves S_DONE, and
//   the time per word is set by the shared-multiplier hash and the one-read-per-cycle probe walk
// reset: synchronous active low; afterwards a clearing pass writes the empty marker to
//   all CAPACITY slots, one per cycle, with in_ready low during the clearing cycles
// ---------------------------------------------------------------------------
// open_addressing_key_table_top
// hashed key table with triangular probing, lookup and insert commands
// ---------------------------------------------------------------------------
module open_addressing_key_table_top #(
  parameter int CAPACITY = oakt_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [oakt_pkg::KEY_W-1:0]    in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [oakt_pkg::SLOT_W-1:0]   out_slot,
  output logic                          out_found,
  output logic                          out_inserted,
  output logic [oakt_pkg::STATUS_W-1:0] out_status
);
  import oakt_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  // item flow: hash, then probe, then wait for the output register; the empty marker goes straight to the wait
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_DONE  = 4'b1000
  } top_state_t;

  top_state_t       state_r, state_nxt;
  logic             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic             bad_r, bad_nxt;
  logic             accept;

  logic             hash_done;
  logic [KEY_W-1:0] hash;
  logic             tbl_ready, tbl_done, tbl_start;
  oakt_res_t        tbl_res;

  logic             out_valid_r, out_valid_nxt;
  oakt_res_t        out_r, res_sel;
  logic             out_load;

  assign in_ready = (state_r == S_IDLE) && tbl_ready;
  assign accept   = in_valid && in_ready;

  oakt_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && (in_key != EMPTY_KEY)),
    .key   (in_key),
    .done  (hash_done),
    .hash  (hash)
  );

  // probe starts the cycle the hash lands
  assign tbl_start = (state_r == S_HASH) && hash_done;

  oakt_table #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (tbl_start),
    .cmd      (cmd_r),
    .key      (key_r),
    .hash_idx (hash[AW-1:0]),
    .ready    (tbl_ready),
    .done     (tbl_done),
    .res      (tbl_res)
  );

  // empty-marker key never touches the table
  always_comb begin
    if (bad_r) begin
      res_sel.slot     = '0;
      res_sel.found    = 1'b0;
      res_sel.inserted = 1'b0;
      res_sel.status   = STATUS_BAD_KEY;
    end else begin
      res_sel = tbl_res;
    end
  end

  // a finished result moves on once the output register is free
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    bad_nxt   = bad_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          bad_nxt   = (in_key == EMPTY_KEY);
          state_nxt = (in_key == EMPTY_KEY) ? S_DONE : S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (tbl_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
    end
    if (out_load) begin
      out_r <= res_sel;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_slot     = out_r.slot;
  assign out_found    = out_r.found;
  assign out_inserted = out_r.inserted;
  assign out_status   = out_r.status;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the open addressing key table: a scoreboard
// predicts every reply from its own copy of the table and compares in order
// ---------------------------------------------------------------------------
module tb;
  import oakt_pkg::*;

  localparam int TB_CAP         = CAPACITY_DEF;
  localparam int IDX_W          = $clog2(TB_CAP);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 600;
  localparam int PHASE_WORDS    = 375;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
  } key_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_cmd = CMD_LOOKUP;
  logic [KEY_W-1:0]    in_key = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_found;
  logic                out_inserted;
  logic [STATUS_W-1:0] out_status;

  // stimulus side: words waiting to be offered and keys known to the bench
  key_word_t        pend_words[$];
  key_word_t        next_word;
  logic [KEY_W-1:0] known_keys[$];
  int unsigned      send_idle_pct = 0;
  int unsigned      rx_stall_pct  = 0;
  bit               rx_hold = 1'b0;

  // scoreboard: shadow table and replies still owed by the block
  logic [KEY_W-1:0] shadow_slots[TB_CAP];
  int unsigned      shadow_count = 0;
  int unsigned      deepest_probe = 0;
  oakt_res_t        expected_replies[$];
  oakt_res_t        want;
  oakt_res_t        owed;
  oakt_res_t        got;

  // run statistics
  int unsigned mismatch_cnt  = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned checked_cnt   = 0;
  int unsigned hit_cnt       = 0;
  int unsigned inserted_cnt  = 0;
  int unsigned refused_cnt   = 0;
  int unsigned bad_key_cnt   = 0;
  int unsigned quiet_cycles  = 0;

  open_addressing_key_table_top #(
    .CAPACITY(TB_CAP)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_slot    (out_slot),
    .out_found   (out_found),
    .out_inserted(out_inserted),
    .out_status  (out_status)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // murmur3 64-bit finalizer: xor-shift, multiply, twice, final xor-shift
  function automatic logic [KEY_W-1:0] fmix64_hash(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = k ^ (k >> MIX_SHIFT);
    h = h * MIX_MUL_A;
    h = h ^ (h >> MIX_SHIFT);
    h = h * MIX_MUL_B;
    h = h ^ (h >> MIX_SHIFT);
    return h;
  endfunction

  // walk the triangular probe path in the shadow table, update it on insert
  // and return the reply the block owes for this word
  function automatic oakt_res_t probe_and_update(input logic cmd,
                                                 input logic [KEY_W-1:0] key);
    oakt_res_t        res;
    logic [KEY_W-1:0] h;
    logic [KEY_W-1:0] pos;
    logic [IDX_W-1:0] idx;
    logic             hit;
    int               p;
    res = '0;
    // the empty marker is never hashed or stored
    if (key == EMPTY_KEY) begin
      res.status = STATUS_BAD_KEY;
      return res;
    end
    h   = fmix64_hash(key);
    idx = h[IDX_W-1:0];
    hit = 1'b0;
    p   = 0;
    while (!hit && p < TB_CAP) begin
      pos = h + KEY_W'((p + p * p) / 2);
      idx = pos[IDX_W-1:0];
      if (shadow_slots[idx] == key) begin
        hit       = 1'b1;
        res.found = 1'b1;
      end else if (shadow_slots[idx] == EMPTY_KEY) begin
        hit = 1'b1;
      end
      if (hit) begin
        if (p > deepest_probe) deepest_probe = p;
      end else begin
        p++;
      end
    end
    // path exhausted: report the home slot
    if (!hit) idx = h[IDX_W-1:0];
    if (cmd == CMD_INSERT && !res.found) begin
      if (!hit || shadow_count >= TB_CAP / 2) begin
        res.status = STATUS_FULL;
      end else begin
        shadow_slots[idx] = key;
        shadow_count++;
        res.inserted = 1'b1;
      end
    end
    res.slot = SLOT_W'(idx);
    return res;
  endfunction

  // sender: offers the next pending word, idles at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pend_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = pend_words.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= next_word.cmd;
        in_key   <= next_word.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or a solid hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // input monitor: every accepted word moves the shadow table forward
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      want = probe_and_update(in_cmd, in_key);
      expected_replies.push_back(want);
      accepted_cnt++;
      if (want.found) hit_cnt++;
      if (want.inserted) inserted_cnt++;
      if (want.status == STATUS_FULL) refused_cnt++;
      if (want.status == STATUS_BAD_KEY) bad_key_cnt++;
    end
  end

  // output monitor: in-order compare against the oldest owed reply
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = '{slot: out_slot, found: out_found, inserted: out_inserted,
              status: out_status};
      if (expected_replies.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: slot %0d found %0b inserted %0b status %0d",
                   got.slot, got.found, got.inserted, got.status);
      end else begin
        owed = expected_replies.pop_front();
        checked_cnt++;
        if (got.slot !== owed.slot || got.found !== owed.found ||
            got.inserted !== owed.inserted || got.status !== owed.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected slot %0d found %0b inserted %0b status %0d%s",
                     checked_cnt, owed.slot, owed.found, owed.inserted, owed.status,
                     $sformatf(", got slot %0d found %0b inserted %0b status %0d",
                               got.slot, got.found, got.inserted, got.status));
        end
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results owed",
                 quiet_cycles, expected_replies.size());
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_word(input logic cmd, input logic [KEY_W-1:0] key);
    pend_words.push_back('{cmd: cmd, key: key});
    if (cmd == CMD_INSERT && key != EMPTY_KEY) known_keys.push_back(key);
  endtask

  // caller waits here until every pending word is sent and every owed reply has come back
  task automatic wait_quiet();
    while (pend_words.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_known_key();
    if (known_keys.size() == 0) return {$urandom(), $urandom()};
    return known_keys[$urandom_range(known_keys.size() - 1)];
  endfunction

  // one random phase: fresh inserts fill the table over the run, the rest
  // revisits stored keys, probes absent ones and throws in odd shapes
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit with_hold);
    int unsigned      pick;
    logic             cmd;
    logic [KEY_W-1:0] key;
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      pick = $urandom_range(99);
      cmd  = CMD_LOOKUP;
      key  = {$urandom(), $urandom()};
      if (pick < 40) begin
        cmd = CMD_INSERT;
      end else if (pick < 58) begin
        key = pick_known_key();
      end else if (pick < 66) begin
        cmd = CMD_INSERT;
        key = pick_known_key();
      end else if (pick < 84) begin
        // absent key lookup, walks to an empty slot
      end else if (pick < 89) begin
        cmd = 1'($urandom_range(1));
        key = EMPTY_KEY;
      end else begin
        cmd = 1'($urandom_range(1));
        case ($urandom_range(2))
          0:       key = ~(64'd1 << $urandom_range(63));
          1:       key = 64'd1 << $urandom_range(63);
          default: key = 64'($urandom_range(15));
        endcase
      end
      push_word(cmd, key);
    end
    // receiver goes dark while the sender keeps pushing, so the block backs up
    if (with_hold) begin
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      rx_hold = 1'b0;
    end
    wait_quiet();
  endtask

  initial begin
    logic [KEY_W-1:0] base_key;
    logic [KEY_W-1:0] scan_key;
    logic [KEY_W-1:0] colliders[$];
    for (int i = 0; i < TB_CAP; i++) shadow_slots[i] = EMPTY_KEY;

    // three keys sharing the home slot of base_key, for a probe chain of known depth
    base_key = 64'h0123_4567_89ab_cdef;
    scan_key = 64'd1;
    while (colliders.size() < 3) begin
      if (fmix64_hash(scan_key) % TB_CAP == fmix64_hash(base_key) % TB_CAP)
        colliders.push_back(scan_key);
      scan_key++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extremes of the key, empty marker, collisions
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    push_word(CMD_LOOKUP, 64'd0);
    push_word(CMD_INSERT, 64'd0);
    push_word(CMD_INSERT, 64'd0);
    push_word(CMD_LOOKUP, 64'd0);
    push_word(CMD_LOOKUP, EMPTY_KEY);
    push_word(CMD_INSERT, EMPTY_KEY);
    push_word(CMD_INSERT, EMPTY_KEY - 1);
    push_word(CMD_LOOKUP, EMPTY_KEY - 1);
    push_word(CMD_INSERT, 64'h8000_0000_0000_0000);
    push_word(CMD_INSERT, 64'h7fff_ffff_ffff_ffff);
    push_word(CMD_INSERT, 64'h5555_5555_5555_5555);
    push_word(CMD_INSERT, 64'haaaa_aaaa_aaaa_aaaa);
    push_word(CMD_INSERT, base_key);
    push_word(CMD_INSERT, colliders[0]);
    push_word(CMD_INSERT, colliders[1]);
    push_word(CMD_LOOKUP, colliders[1]);
    push_word(CMD_LOOKUP, colliders[0]);
    push_word(CMD_LOOKUP, colliders[2]);
    wait_quiet();

    // random phases with different idling, first one with the long hold-off
    run_phase(0, 0, 1'b1);
    run_phase(86, 0, 1'b0);
    run_phase(0, 86, 1'b0);
    run_phase(26, 26, 1'b0);

    // top the table up to half load if the random part fell short
    while (shadow_count < TB_CAP / 2) begin
      repeat (TB_CAP / 2 - shadow_count) push_word(CMD_INSERT, {$urandom(), $urandom()});
      wait_quiet();
    end

    // directed at half load: refusal, present key still found, plain lookups, empty-marker insert
    push_word(CMD_INSERT, {$urandom(), $urandom()});
    push_word(CMD_INSERT, pick_known_key());
    push_word(CMD_LOOKUP, pick_known_key());
    push_word(CMD_LOOKUP, {$urandom(), $urandom()});
    push_word(CMD_INSERT, EMPTY_KEY);
    wait_quiet();

    // let any stray reply surface before the verdict
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_replies.size() != 0) mismatch_cnt++;

    $display("summary: %0d words in, %0d results checked, %0d of %0d slots filled",
             accepted_cnt, checked_cnt, shadow_count, TB_CAP);
    $display("summary: %0d hits, %0d inserts, %0d refused at half load, %0d bad keys, %0s %0d",
             hit_cnt, inserted_cnt, refused_cnt, bad_key_cnt, "deepest probe",
             deepest_probe);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
